@@ src/jcrl_pkg.sv @@
// Package with the types and constants shared by the joint command rate limiter.
package jcrl_pkg;

    // Gripper rail scale 2*pi/0.053 as Q8.20.
    localparam logic signed [27:0] LIN_SCALE_Q20 = 28'sd124309383;
    localparam logic signed [4:0]  TRACK_GAIN    = 5'sd10;
    localparam logic signed [32:0] CHANGE_THRESH = 33'sd104;

    localparam logic [30:0] RST_MAX_STEP     = 31'd524288;
    localparam logic [30:0] RST_MAX_SPEED    = 31'd3145728;
    localparam logic [11:0] RST_LOOP_RATE_HZ = 12'd500;
    localparam logic [3:0]  RST_LINEAR_JOINT = 4'd8;

    typedef enum logic [2:0] {
        CFG_MIT_MODE      = 3'd0,
        CFG_MAX_STEP      = 3'd1,
        CFG_MAX_SPEED     = 3'd2,
        CFG_LOOP_RATE_HZ  = 3'd3,
        CFG_LINEAR_JOINT  = 3'd4,
        CFG_OUTPUT_ENABLE = 3'd5
    } t_cfg_idx;

    typedef enum logic {
        CMD_CONTROL = 1'b0,
        CMD_PRESET  = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_DIFF,
        ST_VEL1,
        ST_VEL2,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic               cmd;
        logic [2:0]         joint;
        logic signed [31:0] position_command;
        logic signed [31:0] measured_position;
        logic               measured_valid;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         joint_out;
        logic               mit_frame;
        logic signed [31:0] position_target;
        logic signed [31:0] velocity_target;
        logic               step_limited;
        logic               speed_limited;
    } t_out_item;

    typedef struct packed {
        logic        mit_mode;
        logic [30:0] max_step;
        logic [30:0] max_speed;
        logic [11:0] loop_rate_hz;
        logic [3:0]  linear_joint;
        logic        output_enable;
    } t_cfg;

    // Saturate a sign-extended value to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

@@ src/jcrl_cfg.sv @@
// Configuration register file of the joint command rate limiter.
module jcrl_cfg import jcrl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_wdata,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mit_mode      <= 1'b0;
            r_cfg.max_step      <= RST_MAX_STEP;
            r_cfg.max_speed     <= RST_MAX_SPEED;
            r_cfg.loop_rate_hz  <= RST_LOOP_RATE_HZ;
            r_cfg.linear_joint  <= RST_LINEAR_JOINT;
            r_cfg.output_enable <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MIT_MODE:      r_cfg.mit_mode      <= i_cfg_wdata[0];
                CFG_MAX_STEP:      r_cfg.max_step      <= i_cfg_wdata;
                CFG_MAX_SPEED:     r_cfg.max_speed     <= i_cfg_wdata;
                CFG_LOOP_RATE_HZ:  r_cfg.loop_rate_hz  <= i_cfg_wdata[11:0];
                CFG_LINEAR_JOINT:  r_cfg.linear_joint  <= i_cfg_wdata[3:0];
                CFG_OUTPUT_ENABLE: r_cfg.output_enable <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/jcrl_mem.sv @@
// Previous-command memory with a registered read port and per-entry valid bits.
module jcrl_mem #(
    parameter int JOINTS = 8,
    parameter int AW     = 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [AW-1:0]        i_rd_addr,
    output logic signed [31:0]   o_rd_data,
    input  logic                 i_wr_en,
    input  logic [AW-1:0]        i_wr_addr,
    input  logic signed [31:0]   i_wr_data
);

    logic signed [31:0] r_mem [JOINTS];
    logic [JOINTS-1:0]  r_vld;
    logic signed [31:0] r_rd_data;
    logic               r_rd_vld;

    // An entry never written since reset reads as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : 32'sd0;

endmodule

@@ src/joint_command_rate_limiter.sv @@
// Top level of the joint command rate limiter: sequencer and fixed-point datapath.
//
// Usage: each input beat on the i_in_* channel names a joint and carries its
// commanded and measured positions. A control beat produces one result beat on
// the o_out_* channel with the limited position target and the velocity target;
// a preset beat loads the joint's previous command and produces no result.
// Beats for joints at or above JOINTS, and control beats while output_enable
// is 0, are dropped and leave the state alone.
// The block works on one beat at a time. A control beat passes through the
// chain scale multiply, saturate, difference and clamp, velocity multiply,
// velocity sum and final clamp, each one register stage, around a single
// read-modify-write of the previous-command memory; a preset beat writes
// its command to the memory in the difference stage and stops there.
// The result sits in an output register, so the next beat is taken while a
// result still waits; if the receiver stalls, the following control beat waits
// in its last stage until the output register is free.
// Configuration writes are registered; the user makes them while the block is
// idle, which the block does not enforce. Reset sets the registers to their
// defaults and marks every previous command as zero; no clearing pass is needed.
module joint_command_rate_limiter import jcrl_pkg::*; #(
    parameter int JOINTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_wdata
);

    localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    t_cfg cfg;

    t_state r_state, n_state;

    // Item registers.
    t_in_item           r_in;
    logic               r_lin;
    logic signed [59:0] r_prod;
    logic signed [31:0] r_cmd_m;
    logic signed [31:0] r_prev;
    logic signed [31:0] r_meas;
    logic signed [32:0] r_err;
    logic signed [32:0] r_chg;
    logic               r_step_lim;
    logic signed [45:0] r_prodv;
    logic signed [36:0] r_err10;
    logic signed [31:0] r_tgt;
    logic               r_big;
    logic signed [46:0] r_vel;

    // Output register.
    logic      r_out_valid;
    t_out_item r_out;

    // Memory ports.
    logic               mem_rd_en;
    logic signed [31:0] mem_rd_data;
    logic               mem_wr_en;
    logic signed [31:0] mem_wr_data;

    logic in_acc;
    logic item_ok;
    logic out_load;

    // Combinational datapath terms.
    logic signed [60:0] rnd;
    logic signed [40:0] scaled;
    logic signed [31:0] cmd_m;
    logic signed [32:0] err;
    logic signed [32:0] chg;
    logic signed [32:0] lim;
    logic signed [46:0] vel;
    logic signed [46:0] spd;
    logic signed [46:0] vel_c;
    logic               spd_lim;

    jcrl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    jcrl_mem #(
        .JOINTS (JOINTS),
        .AW     (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (AW'(i_in_data.joint)),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (AW'(r_in.joint)),
        .i_wr_data (mem_wr_data)
    );

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // Beats for missing joints and disabled control beats are taken and dropped.
    assign item_ok = (({29'd0, i_in_data.joint}) < 32'(JOINTS))
                     && ((i_in_data.cmd == CMD_PRESET) || cfg.output_enable);

    assign mem_rd_en = in_acc && item_ok;

    // Linear-joint scaling: round to nearest with ties upward, then saturate.
    assign rnd    = 61'(r_prod) + 61'sd524288;
    assign scaled = 41'(rnd >>> 20);
    assign cmd_m  = r_lin ? sat32(64'(scaled)) : r_in.position_command;

    // Error uses the command before the step clamp.
    assign err = 33'(r_cmd_m) - 33'(r_meas);
    assign chg = 33'(r_cmd_m) - 33'(r_prev);
    assign lim = $signed({2'b00, cfg.max_step});

    // Velocity rule and clamp.
    assign vel = cfg.mit_mode ? 47'(r_prodv)
                              : (47'(r_err10) + (r_big ? 47'(r_prodv) : 47'sd0));
    assign spd = $signed({16'd0, cfg.max_speed});

    always_comb begin
        vel_c   = r_vel;
        spd_lim = 1'b0;
        if (r_vel > spd) begin
            vel_c   = spd;
            spd_lim = 1'b1;
        end else if (r_vel < -spd) begin
            vel_c   = -spd;
            spd_lim = 1'b1;
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        mem_wr_en   = 1'b0;
        mem_wr_data = r_tgt;
        out_load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && item_ok) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:   n_state = ST_SCALE;
            ST_SCALE: n_state = ST_DIFF;
            ST_DIFF: begin
                if (r_in.cmd == CMD_PRESET) begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = r_cmd_m;
                    n_state     = ST_IDLE;
                end else begin
                    n_state = ST_VEL1;
                end
            end
            ST_VEL1: n_state = ST_VEL2;
            ST_VEL2: n_state = ST_OUT;
            ST_OUT: begin
                // Hold here until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    out_load  = 1'b1;
                    mem_wr_en = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_acc && item_ok) begin
            r_in  <= i_in_data;
            r_lin <= ({1'b0, i_in_data.joint} == cfg.linear_joint);
        end
        case (r_state)
            ST_MUL: begin
                r_prod <= 60'(r_in.position_command) * 60'(LIN_SCALE_Q20);
            end
            ST_SCALE: begin
                r_cmd_m <= cmd_m;
                r_prev  <= mem_rd_data;
                r_meas  <= r_in.measured_valid ? r_in.measured_position : mem_rd_data;
            end
            ST_DIFF: begin
                r_err      <= err;
                r_step_lim <= (chg > lim) || (chg < -lim);
                if (chg > lim) begin
                    r_chg <= lim;
                end else if (chg < -lim) begin
                    r_chg <= -lim;
                end else begin
                    r_chg <= chg;
                end
            end
            ST_VEL1: begin
                r_prodv <= 46'(r_chg) * $signed({34'd0, cfg.loop_rate_hz});
                r_err10 <= 37'(r_err) * 37'(TRACK_GAIN);
                r_tgt   <= sat32(64'(r_prev) + 64'(r_chg));
                r_big   <= (r_chg > CHANGE_THRESH) || (r_chg < -CHANGE_THRESH);
            end
            ST_VEL2: begin
                r_vel <= vel;
            end
            default: ;
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out.joint_out       <= r_in.joint;
            r_out.mit_frame       <= cfg.mit_mode || (r_in.joint == 3'd0);
            r_out.position_target <= r_tgt;
            r_out.velocity_target <= vel_c[31:0];
            r_out.step_limited    <= r_step_lim;
            r_out.speed_limited   <= spd_lim;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ src/jcrl_checker.sv @@
// Port-level checker for the joint command rate limiter and its bind statement.
module jcrl_checker import jcrl_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input t_in_item    i_in_data,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input t_out_item   o_out_data,
    input logic        i_cfg_we
);

    // A stalled result beat stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    // A new result is only produced at the end of an item's work.
    a_out_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared while input side was idle");

    // Joint zero always receives an MIT frame.
    a_joint0_mit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.joint_out == 3'd0) |-> o_out_data.mit_frame)
        else $error("joint zero without MIT frame");

    // Register writes only arrive while nothing is in flight.
    a_cfg_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |-> o_in_ready && !o_out_valid)
        else $error("register write while a beat was in flight");

endmodule

bind joint_command_rate_limiter jcrl_checker u_jcrl_checker (.*);
